[src/i2csrm_pkg.sv]
// Package for the I2C slave register memory: transfer structs, event codes,
// transaction phase type and the control struct between controller and top level.
// No dependencies.
package i2csrm_pkg;

	localparam int MEM_DEPTH_DEF = 4096;

	localparam logic [1:0] EV_STOP  = 2'd0;
	localparam logic [1:0] EV_MATCH = 2'd1;
	localparam logic [1:0] EV_DATA  = 2'd2;
	localparam logic [1:0] EV_ERROR = 2'd3;

	typedef enum logic [2:0] {
		PH_UNINIT = 3'd0,
		PH_ERROR  = 3'd1,
		PH_HIGH   = 3'd2,
		PH_LOW    = 3'd3,
		PH_LEGAL  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       is_write;
		logic [7:0] write_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] send_byte;
		logic       is_dummy;
	} out_item_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic dummy;
	} mem_ctl_t;

endpackage

[src/i2c_slave_register_memory.sv]
// Top level of the I2C slave register memory: byte store, clearing sweep and
// result register. Depends on i2csrm_pkg and i2csrm_ctrl.
//
// One bus event is taken per clock while busy is low. A read event gives its
// byte on result in the cycle after the transfer, with strobe high for exactly
// that cycle; the receiver cannot stall, so it must take it then. Writes,
// stops and bus errors give no result. The store is a single-port memory of
// MEM_DEPTH bytes with a registered read, one access per event. After reset,
// busy stays high while the memory is swept to zero.
module i2c_slave_register_memory #(
	parameter int MEM_DEPTH = i2csrm_pkg::MEM_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  i2csrm_pkg::in_item_t  item,
	output logic                  strobe,
	output i2csrm_pkg::out_item_t result
);
	import i2csrm_pkg::*;

	localparam int IW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	mem_ctl_t      ctl;
	logic [IW-1:0] ptr;
	logic          accept;
	logic          clr_q;
	logic [IW-1:0] clr_addr_q;
	logic [7:0]    mem_q [MEM_DEPTH];
	logic [7:0]    rd_q;
	logic          strobe_s1;
	logic          dummy_s1;

	assign accept = start && !busy;
	assign busy   = clr_q;

	i2csrm_ctrl #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (item),
		.ctl   (ctl),
		.ptr   (ptr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == IW'(MEM_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (ctl.wr_en) begin
			mem_q[ptr] <= item.write_byte;
		end
		if (ctl.rd_en) begin
			rd_q <= mem_q[ptr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= ctl.rd_en || ctl.dummy;
		end
	end

	always_ff @(posedge clk) begin
		dummy_s1 <= ctl.dummy;
	end

	assign strobe           = strobe_s1;
	assign result.is_dummy  = dummy_s1;
	assign result.send_byte = dummy_s1 ? '0 : rd_q;

endmodule

[src/i2csrm_ctrl.sv]
// Transaction controller: phase and address pointer, memory access decode.
// Depends on i2csrm_pkg.
module i2csrm_ctrl #(
	parameter int MEM_DEPTH = i2csrm_pkg::MEM_DEPTH_DEF,
	localparam int IW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  i2csrm_pkg::in_item_t item,
	output i2csrm_pkg::mem_ctl_t ctl,
	output logic [IW-1:0]        ptr
);
	import i2csrm_pkg::*;

	phase_t        phase_q, phase_d;
	logic [IW-1:0] ptr_q, ptr_d;
	logic [IW-1:0] ptr_adv;
	logic [IW-1:0] hi_tab [256];
	logic [IW-1:0] lo_tab [256];
	logic [IW:0]   low_sum;
	logic [IW-1:0] low_ptr;

	// (byte << 8) mod depth and byte mod depth, resolved at elaboration
	for (genvar g = 0; g < 256; g++) begin : g_tab
		localparam int HiMod = (g * 256) % MEM_DEPTH;
		localparam int LoMod = g % MEM_DEPTH;
		assign hi_tab[g] = IW'(HiMod);
		assign lo_tab[g] = IW'(LoMod);
	end

	assign ptr_adv = (ptr_q == IW'(MEM_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
	assign low_sum = {1'b0, ptr_q} + {1'b0, lo_tab[item.write_byte]};
	assign low_ptr = (low_sum >= (IW + 1)'(MEM_DEPTH)) ?
		IW'(low_sum - (IW + 1)'(MEM_DEPTH)) : IW'(low_sum);

	always_comb begin
		phase_d = phase_q;
		ptr_d   = ptr_q;
		if (accept) begin
			case (item.mode)
				EV_MATCH: begin
					if (item.is_write) begin
						phase_d = PH_HIGH;
						ptr_d   = '0;
					end else if (phase_q == PH_LEGAL) begin
						phase_d = PH_UNINIT;
						ptr_d   = ptr_adv;
					end else begin
						phase_d = PH_ERROR;
					end
				end
				EV_DATA: begin
					if (item.is_write) begin
						case (phase_q)
							PH_HIGH: begin
								phase_d = PH_LOW;
								ptr_d   = hi_tab[item.write_byte];
							end
							PH_LOW: begin
								phase_d = PH_LEGAL;
								ptr_d   = low_ptr;
							end
							default: begin
								ptr_d = ptr_adv;
							end
						endcase
					end else if (!(phase_q inside {PH_LEGAL, PH_ERROR})) begin
						ptr_d = ptr_adv;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		ctl = '0;
		if (accept) begin
			case (item.mode)
				EV_MATCH: begin
					if (!item.is_write) begin
						ctl.rd_en = (phase_q == PH_LEGAL);
						ctl.dummy = (phase_q != PH_LEGAL);
					end
				end
				EV_DATA: begin
					if (item.is_write) begin
						ctl.wr_en = !(phase_q inside {PH_HIGH, PH_LOW});
					end else begin
						ctl.dummy = (phase_q inside {PH_LEGAL, PH_ERROR});
						ctl.rd_en = !(phase_q inside {PH_LEGAL, PH_ERROR});
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_UNINIT;
			ptr_q   <= '0;
		end else begin
			phase_q <= phase_d;
			ptr_q   <= ptr_d;
		end
	end

	assign ptr = ptr_q;

endmodule

[src/i2csrm_checker.sv]
// Port-level checker for the I2C slave register memory, bound to the top level.
// Depends on i2csrm_pkg.
module i2csrm_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input i2csrm_pkg::in_item_t  item,
	input logic                  strobe,
	input i2csrm_pkg::out_item_t result
);
	import i2csrm_pkg::*;

	logic accept;
	assign accept = start && !busy;

	a_dummy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.is_dummy |-> result.send_byte == 8'h00)
		else $error("dummy result carries a nonzero byte");

	a_strobe_cause: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(accept))
		else $error("result without a transfer in the cycle before");

	a_quiet_events: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item.mode == EV_STOP || item.mode == EV_ERROR ||
			(item.mode == EV_MATCH && item.is_write) ||
			(item.mode == EV_DATA && item.is_write)) |=> !strobe)
		else $error("result for an event that gives none");

	a_read_match: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.mode == EV_MATCH && !item.is_write |=> strobe)
		else $error("read address match gave no result");

	a_read_data: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.mode == EV_DATA && !item.is_write |=> strobe)
		else $error("read data event gave no result");

endmodule

bind i2c_slave_register_memory i2csrm_checker u_i2csrm_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.item  (item),
	.strobe(strobe),
	.result(result)
);
